>>> rtl/hrhp_pkg.sv
// Shared types, constants, character helpers and status classification for the HTTP response header parser.
// No dependencies; compiled first.
package hrhp_pkg;

   localparam int BYTE_W    = 8;
   localparam int CODE_W    = 16;
   localparam int CLEN_W    = 32;
   localparam int ACTION_W  = 3;
   localparam int HDRLEN_W  = 16;

   localparam int PREFIX_LEN = 5;
   localparam int KEY_LEN    = 15;

   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_CR  = 8'h0d;
   localparam logic [7:0] CHAR_LF  = 8'h0a;
   localparam logic [7:0] CHAR_DOT = 8'h2e;

   typedef enum logic [ACTION_W-1:0] {
      ACT_SUCCESS    = 3'd0,
      ACT_REDIRECT   = 3'd1,
      ACT_RETRY      = 3'd2,
      ACT_LONG_RETRY = 3'd3,
      ACT_FATAL      = 3'd4
   } action_type;

   function automatic logic is_digit(input logic [7:0] b);
      return b inside {[8'h30:8'h39]};
   endfunction

   // Expected characters of "HTTP/".
   function automatic logic [7:0] prefix_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0:    c = 8'h48;
         3'd1:    c = 8'h54;
         3'd2:    c = 8'h54;
         3'd3:    c = 8'h50;
         3'd4:    c = 8'h2f;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // Expected characters of "Content-Length:".
   function automatic logic [7:0] key_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h6f;
         4'd2:    c = 8'h6e;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6e;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2d;
         4'd8:    c = 8'h4c;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6e;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         4'd14:   c = 8'h3a;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic action_type classify(input logic [CODE_W-1:0] code);
      action_type a;
      case (code)
         16'd100, 16'd200, 16'd203, 16'd204, 16'd205, 16'd206: a = ACT_SUCCESS;
         16'd301:                                             a = ACT_REDIRECT;
         16'd408, 16'd500, 16'd504:                           a = ACT_RETRY;
         16'd503:                                             a = ACT_LONG_RETRY;
         default:                                             a = ACT_FATAL;
      endcase
      return a;
   endfunction

endpackage

>>> rtl/hrhp_if.sv
// Valid/ready channel interfaces for the header byte stream and the parse result.
// Depends on hrhp_pkg for field widths.
interface hrhp_req_if;
   import hrhp_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hrhp_rsp_if;
   import hrhp_pkg::*;
   logic                valid;
   logic                ready;
   logic [CODE_W-1:0]   status_code;
   logic                status_error;
   logic [CLEN_W-1:0]   content_length;
   logic [ACTION_W-1:0] action;
   logic                header_too_long;
   logic [HDRLEN_W-1:0] header_length;

   modport source (output valid, output status_code, output status_error,
                   output content_length, output action, output header_too_long,
                   output header_length, input ready);
   modport sink   (input valid, input status_code, input status_error,
                   input content_length, input action, input header_too_long,
                   input header_length, output ready);
endinterface

>>> rtl/hrhp_dec_acc.sv
// Saturating decimal accumulator: value * 10 + digit, clamped to all ones.
// No package dependency; used by http_response_header_parser.
module hrhp_dec_acc #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0] value,
   input  logic [3:0]       digit,
   output logic [WIDTH-1:0] result
);
   logic [WIDTH+3:0] wide;
   logic [WIDTH+3:0] sum;

   // Times ten is times eight plus times two.
   assign wide   = {4'b0000, value};
   assign sum    = (wide << 3) + (wide << 1) + {{WIDTH{1'b0}}, digit};
   assign result = (|sum[WIDTH+3:WIDTH]) ? {WIDTH{1'b1}} : sum[WIDTH-1:0];
endmodule

>>> rtl/http_response_header_parser.sv
// HTTP response header parser: status code, Content-Length and action class.
// Depends on hrhp_pkg, the hrhp_req_if / hrhp_rsp_if interfaces and hrhp_dec_acc.
//
// Usage. Header bytes arrive one beat at a time on req_chan (rx_byte). The block
// checks that the status line reads "HTTP/", a version of digits and dots, spaces
// and a decimal status code, and takes the value of the first "Content-Length:"
// line. When CRLFCRLF has been seen, or MAX_HEADER_BYTES bytes have arrived, one
// result beat is offered on rsp_chan and the parser clears itself for the next
// response; the very next byte may already belong to it.
// Throughput is one byte per clock unless a header-ending byte waits on a stalled
// rsp_chan. A byte is captured in an input register, then the parsing logic (a
// multiply-by-ten-and-add for the decimal fields and the status classification)
// writes the state and the result register that offers the result beat.
// Reset (synchronous, active high) returns all parse state to the start of a
// header and drops both valid flags. While rsp_chan is stalled with a result
// waiting, bytes that do not end a header are still taken; only a byte that ends
// another header waits in the input register, and req_chan.ready falls until the
// waiting result beat has been taken.
module http_response_header_parser #(
   parameter int MAX_HEADER_BYTES = 65535,
   parameter int MAX_DIGITS       = 32
) (
   input  logic          clock,
   input  logic          reset,
   hrhp_req_if.sink      req_chan,
   hrhp_rsp_if.source    rsp_chan
);
   import hrhp_pkg::*;

   localparam int CNT_W = $clog2(MAX_HEADER_BYTES + 1);
   localparam int DIG_W = $clog2(MAX_DIGITS + 1);

   typedef enum logic [2:0] {
      SP_PREFIX,
      SP_VERSION,
      SP_SPACES,
      SP_DIGITS,
      SP_DONE
   } status_phase_type;

   typedef enum logic [1:0] {
      LP_SEARCH,
      LP_SKIP,
      LP_DIGITS,
      LP_DONE
   } length_phase_type;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;

   // Parse state.
   status_phase_type  sphase_ff, sphase_in;
   logic [2:0]        prefix_idx_ff, prefix_idx_in;
   logic [CODE_W-1:0] code_ff, code_in;
   logic [DIG_W-1:0]  code_cnt_ff, code_cnt_in;
   logic              code_fail_ff, code_fail_in;
   logic              line_start_ff, line_start_in;
   logic [3:0]        key_idx_ff, key_idx_in;
   length_phase_type  lphase_ff, lphase_in;
   logic [CLEN_W-1:0] len_ff, len_in;
   logic [DIG_W-1:0]  len_cnt_ff, len_cnt_in;
   logic [1:0]        term_ff, term_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0]   rsp_code_ff;
   logic                rsp_err_ff;
   logic [CLEN_W-1:0]   rsp_len_ff;
   action_type          rsp_action_ff;
   logic                rsp_too_long_ff;
   logic [HDRLEN_W-1:0] rsp_hdr_len_ff;

   logic [BYTE_W-1:0] b;
   logic              b_digit;
   logic [CODE_W-1:0] code_acc;
   logic [CLEN_W-1:0] len_acc;
   logic [DIG_W-1:0]  code_cnt_inc;
   logic [CNT_W-1:0]  count_inc;
   logic              ended;
   logic              too_long;
   logic              emit;
   logic              err;
   logic [CODE_W-1:0] code_out;
   action_type        action_out;
   logic              out_free;
   logic              stall;
   logic              advance;

   assign b            = in_byte_ff;
   assign b_digit      = is_digit(b);
   assign code_cnt_inc = code_cnt_ff + 1'b1;
   assign count_inc    = count_ff + 1'b1;

   hrhp_dec_acc #(.WIDTH(CODE_W)) u_code_acc (
      .value  (code_ff),
      .digit  (b[3:0]),
      .result (code_acc)
   );

   hrhp_dec_acc #(.WIDTH(CLEN_W)) u_len_acc (
      .value  (len_ff),
      .digit  (b[3:0]),
      .result (len_acc)
   );

   // Status line: prefix, version, spaces, then code digits. The first digit
   // after the spaces is taken in the same step as the phase change.
   always_comb begin
      sphase_in     = sphase_ff;
      prefix_idx_in = prefix_idx_ff;
      code_in       = code_ff;
      code_cnt_in   = code_cnt_ff;
      code_fail_in  = code_fail_ff;
      case (sphase_ff)
         SP_PREFIX: begin
            if (b == prefix_char(prefix_idx_ff)) begin
               prefix_idx_in = prefix_idx_ff + 1'b1;
               if (prefix_idx_ff == 3'(PREFIX_LEN - 1)) begin
                  sphase_in = SP_VERSION;
               end
            end else begin
               code_fail_in = 1'b1;
               sphase_in    = SP_DONE;
            end
         end
         SP_VERSION: begin
            if (b == CHAR_SP) begin
               sphase_in = SP_SPACES;
            end else if (!b_digit && b != CHAR_DOT) begin
               code_fail_in = 1'b1;
               sphase_in    = SP_DONE;
            end
         end
         SP_SPACES, SP_DIGITS: begin
            if (sphase_ff == SP_SPACES && b == CHAR_SP) begin
               sphase_in = SP_SPACES;
            end else if (!b_digit) begin
               sphase_in = SP_DONE;
            end else begin
               code_in     = code_acc;
               code_cnt_in = code_cnt_inc;
               if (code_cnt_inc >= DIG_W'(MAX_DIGITS)) begin
                  code_fail_in = 1'b1;
                  sphase_in    = SP_DONE;
               end else begin
                  sphase_in = SP_DIGITS;
               end
            end
         end
         default: begin
            sphase_in = SP_DONE;
         end
      endcase
   end

   // Content-Length search. Only lines after the status line are candidates,
   // and an empty line (a bare LF at the start of a line) ends the search.
   always_comb begin
      lphase_in     = lphase_ff;
      line_start_in = line_start_ff;
      key_idx_in    = key_idx_ff;
      len_in        = len_ff;
      len_cnt_in    = len_cnt_ff;
      case (lphase_ff)
         LP_SEARCH: begin
            if (b == CHAR_LF) begin
               if (line_start_ff && key_idx_ff == 4'd0) begin
                  lphase_in = LP_DONE;
               end else begin
                  line_start_in = 1'b1;
                  key_idx_in    = 4'd0;
               end
            end else if (line_start_ff) begin
               if (b == key_char(key_idx_ff)) begin
                  key_idx_in = key_idx_ff + 1'b1;
                  if (key_idx_ff == 4'(KEY_LEN - 1)) begin
                     lphase_in = LP_SKIP;
                  end
               end else begin
                  line_start_in = 1'b0;
               end
            end
         end
         LP_SKIP, LP_DIGITS: begin
            if (lphase_ff == LP_SKIP && b == CHAR_SP) begin
               lphase_in = LP_SKIP;
            end else if (b_digit && len_cnt_ff < DIG_W'(MAX_DIGITS)) begin
               len_in     = len_acc;
               len_cnt_in = len_cnt_ff + 1'b1;
               lphase_in  = LP_DIGITS;
            end else begin
               lphase_in = LP_DONE;
            end
         end
         default: begin
            lphase_in = LP_DONE;
         end
      endcase
   end

   // CRLFCRLF tracking, byte limit and the result fields.
   always_comb begin
      ended = 1'b0;
      if (b == CHAR_CR) begin
         term_in = (term_ff == 2'd2) ? 2'd3 : 2'd1;
      end else if (b == CHAR_LF) begin
         ended   = (term_ff == 2'd3);
         term_in = (term_ff == 2'd1) ? 2'd2 : 2'd0;
      end else begin
         term_in = 2'd0;
      end
      count_in   = count_inc;
      too_long   = !ended && (count_inc >= CNT_W'(MAX_HEADER_BYTES));
      emit       = ended || too_long;
      err        = code_fail_in || sphase_in == SP_PREFIX || sphase_in == SP_VERSION;
      code_out   = err ? '0 : code_in;
      action_out = (err || too_long) ? ACT_FATAL : classify(code_out);
   end

   // Handshake. Only a byte that ends a header needs room in the result register.
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign stall        = in_valid_ff && emit && !out_free;
   assign advance      = in_valid_ff && !stall;
   assign req_chan.ready = !stall;

   always_comb begin
      if (req_chan.valid && !stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sphase_ff     <= SP_PREFIX;
         prefix_idx_ff <= '0;
         code_ff       <= '0;
         code_cnt_ff   <= '0;
         code_fail_ff  <= 1'b0;
         line_start_ff <= 1'b0;
         key_idx_ff    <= '0;
         lphase_ff     <= LP_SEARCH;
         len_ff        <= '0;
         len_cnt_ff    <= '0;
         term_ff       <= '0;
         count_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance && emit) begin
            // Header finished: start afresh for the next response.
            sphase_ff     <= SP_PREFIX;
            prefix_idx_ff <= '0;
            code_ff       <= '0;
            code_cnt_ff   <= '0;
            code_fail_ff  <= 1'b0;
            line_start_ff <= 1'b0;
            key_idx_ff    <= '0;
            lphase_ff     <= LP_SEARCH;
            len_ff        <= '0;
            len_cnt_ff    <= '0;
            term_ff       <= '0;
            count_ff      <= '0;
         end else if (advance) begin
            sphase_ff     <= sphase_in;
            prefix_idx_ff <= prefix_idx_in;
            code_ff       <= code_in;
            code_cnt_ff   <= code_cnt_in;
            code_fail_ff  <= code_fail_in;
            line_start_ff <= line_start_in;
            key_idx_ff    <= key_idx_in;
            lphase_ff     <= lphase_in;
            len_ff        <= len_in;
            len_cnt_ff    <= len_cnt_in;
            term_ff       <= term_in;
            count_ff      <= count_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_chan.valid && !stall) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (advance && emit) begin
         rsp_code_ff     <= code_out;
         rsp_err_ff      <= err;
         rsp_len_ff      <= len_in;
         rsp_action_ff   <= action_out;
         rsp_too_long_ff <= too_long;
         rsp_hdr_len_ff  <= HDRLEN_W'(count_inc);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status_code     = rsp_code_ff;
   assign rsp_chan.status_error    = rsp_err_ff;
   assign rsp_chan.content_length  = rsp_len_ff;
   assign rsp_chan.action          = rsp_action_ff;
   assign rsp_chan.header_too_long = rsp_too_long_ff;
   assign rsp_chan.header_length   = rsp_hdr_len_ff;

   // After a header ends, the next byte is parsed from a clean start.
   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      (advance && emit) |=> (count_ff == '0 && sphase_ff == SP_PREFIX
                             && lphase_ff == LP_SEARCH && term_ff == 2'd0))
      else $error("parse state not cleared after a result beat");

   // The byte limit always ends a header before the counter can pass it.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_HEADER_BYTES))
      else $error("byte count reached the header limit without a result");

   // A failed status line parks the status parser.
   a_fail_done: assert property (@(posedge clock) disable iff (reset)
      code_fail_ff |-> sphase_ff == SP_DONE)
      else $error("status failure outside the done phase");

   // No length digits are gathered before the keyword has matched.
   a_len_idle: assert property (@(posedge clock) disable iff (reset)
      (lphase_ff == LP_SEARCH) |-> (len_ff == '0 && len_cnt_ff == '0))
      else $error("length value moved during the keyword search");

   // A result waiting on a stalled receiver is not overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !(advance && emit))
      else $error("result register overwritten while stalled");

endmodule
